// ===== hw/rtl/rie_pkg.sv =====
package rie_pkg;

   localparam int DATA_WORDS = 1024;
   localparam int NUM_REGS   = 32;
   localparam int DADDR_W    = $clog2(DATA_WORDS);
   localparam int CLEAR_W    = DADDR_W + 1;

   localparam logic [1:0] CAT1_CODE = 2'b01;

   typedef enum logic [3:0] {
      C1_J = 4'd0, C1_JR = 4'd1, C1_BEQ = 4'd2, C1_BLTZ = 4'd3, C1_BGTZ = 4'd4,
      C1_BRK = 4'd5, C1_SW = 4'd6, C1_LW = 4'd7, C1_SLL = 4'd8, C1_SRL = 4'd9,
      C1_SRA = 4'd10
   } cat1_op_type;

   typedef enum logic [3:0] {
      C2_ADD = 4'd0, C2_SUB = 4'd1, C2_MUL = 4'd2, C2_AND = 4'd3, C2_OR = 4'd4,
      C2_XOR = 4'd5, C2_NOR = 4'd6, C2_SLT = 4'd7, C2_ADDI = 4'd8,
      C2_ANDI = 4'd9, C2_ORI = 4'd10, C2_XORI = 4'd11
   } cat2_op_type;

   // one queued item, as the front end leaves it
   typedef struct packed {
      logic        op;
      logic [31:0] pc;
      logic [31:0] instr;
      logic [31:0] load_addr;
      logic [31:0] load_value;
   } item_type;

   typedef struct packed {
      logic [31:0] next_pc;
      logic        halted;
      logic        reg_written;
      logic [4:0]  reg_index;
      logic [31:0] reg_value;
      logic        mem_written;
      logic [31:0] mem_addr;
      logic [31:0] mem_value;
      logic        addr_fault;
   } result_type;

   function automatic logic addr_ok(input logic [31:0] a);
      logic [31:0] wa;
      wa = a >> 2;
      return (a[1:0] == 2'b00) && (wa < 32'(DATA_WORDS));
   endfunction

endpackage

// ===== hw/rtl/rie_queue.sv =====
module rie_queue
   import rie_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_valid,
   output logic     wr_stall,
   input  item_type wr_item,
   output logic     rd_valid,
   input  logic     rd_stall,
   output item_type rd_item
);
   // two-entry queue; full registers both sides
   item_type   mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign wr_stall = (cnt_ff == 2'd2);
   assign rd_valid = (cnt_ff != 2'd0);
   assign rd_item  = mem_ff[rp_ff];
   assign push     = wr_valid && !wr_stall;
   assign pop      = rd_valid && !rd_stall;

   always_comb begin
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= wr_item;
   end
endmodule

// ===== hw/rtl/rie_exec.sv =====
module rie_exec
   import rie_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_stall,
   input  item_type   in_item,
   output logic       out_valid,
   input  logic       out_stall,
   output result_type out_res
);
   // Stage 1 reads registers and memory; stage 2 finishes and writes back.
   typedef enum logic [1:0] {
      ST_CLEAR = 2'b01,
      ST_RUN   = 2'b10
   } state_type;

   state_type         state_ff, state_in;
   logic [CLEAR_W-1:0] clr_ff, clr_in;

   logic [31:0] rf_ff [NUM_REGS];
   logic [31:0] dm_ff [DATA_WORDS];

   // stage 2 registers
   logic        v2_ff, v2_in;
   item_type    it2_ff;
   logic [31:0] a2_ff, b2_ff, md2_ff;
   logic        lwfwd2_ff;
   logic [31:0] lwfwd_val2_ff;

   // output register
   logic        ov_ff, ov_in;
   result_type  res_ff;

   logic        adv2, adv1, run;
   assign run       = (state_ff == ST_RUN);
   assign adv2      = v2_ff && (!ov_ff || !out_stall);
   assign adv1      = run && in_valid && (!v2_ff || adv2);
   assign in_stall  = !(run && (!v2_ff || adv2));
   assign out_valid = ov_ff;
   assign out_res   = res_ff;

   // stage-2 result, combinational
   result_type r;
   logic [31:0] ea, boff, tgt, mul;
   logic        mem_wr;
   logic [DADDR_W-1:0] mem_wa;
   logic [31:0] mem_wd;
   logic [3:0]  opc;
   logic [4:0]  rt, rd, sa;
   logic [31:0] imm, a, b, md;

   always_comb begin
      opc  = it2_ff.instr[29:26];
      rt   = it2_ff.instr[20:16];
      rd   = it2_ff.instr[15:11];
      sa   = it2_ff.instr[10:6];
      imm  = {16'd0, it2_ff.instr[15:0]};
      a    = a2_ff;
      b    = b2_ff;
      md   = lwfwd2_ff ? lwfwd_val2_ff : md2_ff;
      boff = it2_ff.pc + 32'd4 + (imm << 2);
      ea   = a + imm;
      mul  = a * b;
      tgt  = it2_ff.pc;
      r    = '0;
      mem_wr = 1'b0;
      mem_wa = '0;
      mem_wd = '0;
      if (it2_ff.op) begin
         r.mem_addr = it2_ff.load_addr;
         if (addr_ok(it2_ff.load_addr)) begin
            mem_wr = 1'b1;
            mem_wa = it2_ff.load_addr[DADDR_W+1:2];
            mem_wd = it2_ff.load_value;
            r.mem_written = 1'b1;
            r.mem_value   = it2_ff.load_value;
         end else begin
            r.addr_fault = 1'b1;
         end
         r.next_pc = it2_ff.pc;
      end else begin
         if (it2_ff.instr[31:30] == CAT1_CODE) begin
            unique case (opc)
               C1_J:    tgt = {it2_ff.instr[29:0], 2'b00} & 32'h0FFF_FFFC;
               C1_JR:   tgt = a;
               C1_BEQ:  if (a == b) tgt = boff;
               C1_BLTZ: if (a[31]) tgt = boff;
               C1_BGTZ: if (!a[31] && a != 32'd0) tgt = boff;
               C1_BRK:  r.halted = 1'b1;
               C1_SW: begin
                  r.mem_addr = ea;
                  if (addr_ok(ea)) begin
                     mem_wr = 1'b1;
                     mem_wa = ea[DADDR_W+1:2];
                     mem_wd = b;
                     r.mem_written = 1'b1;
                     r.mem_value   = b;
                  end else r.addr_fault = 1'b1;
               end
               C1_LW: begin
                  r.mem_addr = ea;
                  if (addr_ok(ea)) begin
                     r.reg_written = 1'b1;
                     r.reg_index   = rt;
                     r.reg_value   = md;
                  end else r.addr_fault = 1'b1;
               end
               C1_SLL: begin
                  r.reg_written = 1'b1; r.reg_index = rd; r.reg_value = b << sa;
               end
               C1_SRL: begin
                  r.reg_written = 1'b1; r.reg_index = rd; r.reg_value = b >> sa;
               end
               C1_SRA: begin
                  r.reg_written = 1'b1; r.reg_index = rd;
                  r.reg_value = 32'($signed(b) >>> sa);
               end
               default: ;
            endcase
         end else begin
            r.reg_written = 1'b1;
            r.reg_index   = rd;
            unique case (opc)
               C2_ADD:  r.reg_value = a + b;
               C2_SUB:  r.reg_value = a - b;
               C2_MUL:  r.reg_value = mul;
               C2_AND:  r.reg_value = a & b;
               C2_OR:   r.reg_value = a | b;
               C2_XOR:  r.reg_value = a ^ b;
               C2_NOR:  r.reg_value = ~(a | b);
               C2_SLT:  r.reg_value = {31'd0, $signed(a) < $signed(b)};
               C2_ADDI: begin
                  r.reg_index = rt;
                  r.reg_value = a + {{16{imm[15]}}, imm[15:0]};
               end
               C2_ANDI: begin r.reg_index = rt; r.reg_value = a & imm; end
               C2_ORI:  begin r.reg_index = rt; r.reg_value = a | imm; end
               C2_XORI: begin r.reg_index = rt; r.reg_value = a ^ imm; end
               default: begin r.reg_written = 1'b0; r.reg_index = '0; end
            endcase
         end
         r.next_pc = (tgt == it2_ff.pc) ? it2_ff.pc + 32'd4 : tgt;
      end
   end

   // stage-1 reads with forwarding from the instruction now finishing
   logic [4:0]  rs1, rt1;
   logic [31:0] ea1_base;
   logic [31:0] a1, b1;
   logic        wb;
   assign rs1 = in_item.instr[25:21];
   assign rt1 = in_item.instr[20:16];
   assign wb  = adv2 && r.reg_written;

   always_comb begin
      a1 = (wb && r.reg_index == rs1) ? r.reg_value : rf_ff[rs1];
      b1 = (wb && r.reg_index == rt1) ? r.reg_value : rf_ff[rt1];
      ea1_base = a1 + {16'd0, in_item.instr[15:0]};
   end

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      if (state_ff == ST_CLEAR) begin
         clr_in = clr_ff + 1'b1;
         if (clr_ff == CLEAR_W'(DATA_WORDS - 1)) state_in = ST_RUN;
      end
      v2_in = adv1 ? 1'b1 : (adv2 ? 1'b0 : v2_ff);
      ov_in = adv2 ? 1'b1 : ((ov_ff && !out_stall) ? 1'b0 : ov_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         v2_ff    <= 1'b0;
         ov_ff    <= 1'b0;
         for (int i = 0; i < NUM_REGS; i++) rf_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         v2_ff    <= v2_in;
         ov_ff    <= ov_in;
         if (wb) rf_ff[r.reg_index] <= r.reg_value;
      end
      if (adv2) res_ff <= r;
      if (adv1) begin
         it2_ff        <= in_item;
         a2_ff         <= a1;
         b2_ff         <= b1;
         // a store finishing now to the same word overtakes the array read
         lwfwd2_ff     <= adv2 && mem_wr && (mem_wa == ea1_base[DADDR_W+1:2]);
         lwfwd_val2_ff <= mem_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) dm_ff[clr_ff[DADDR_W-1:0]] <= '0;
      else if (adv2 && mem_wr) dm_ff[mem_wa] <= mem_wd;
      if (adv1) md2_ff <= dm_ff[ea1_base[DADDR_W+1:2]];
   end
endmodule

// ===== hw/rtl/risc_instruction_execute_unit.sv =====
// Execute unit for a small 32-bit load/store instruction set. Each accepted beat
// either executes one instruction (req_op=0) or preloads one data-memory word
// (req_op=1) and yields exactly one response beat. A two-entry queue parts the
// request side from a two-stage back end (register/memory read, then execute and
// write back) with forwarding, sustaining one beat per cycle while rsp_stall is
// low; a request passes the queue, stage-2 and output registers. After reset the
// data memory is cleared one word per cycle, and the full queue stalls requests.
module risc_instruction_execute_unit
   import rie_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [31:0] req_pc,
   input  logic [31:0] req_instr,
   input  logic [31:0] req_load_addr,
   input  logic signed [31:0] req_load_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_next_pc,
   output logic        rsp_halted,
   output logic        rsp_reg_written,
   output logic [4:0]  rsp_reg_index,
   output logic signed [31:0] rsp_reg_value,
   output logic        rsp_mem_written,
   output logic [31:0] rsp_mem_addr,
   output logic signed [31:0] rsp_mem_value,
   output logic        rsp_addr_fault
);
   item_type   req_item, q_item;
   logic       q_valid, q_stall;
   result_type res;

   assign req_item = '{op: req_op, pc: req_pc, instr: req_instr,
                       load_addr: req_load_addr, load_value: req_load_value};

   rie_queue u_queue (
      .clock, .reset,
      .wr_valid(req_valid), .wr_stall(req_stall), .wr_item(req_item),
      .rd_valid(q_valid), .rd_stall(q_stall), .rd_item(q_item)
   );

   rie_exec u_exec (
      .clock, .reset,
      .in_valid(q_valid), .in_stall(q_stall), .in_item(q_item),
      .out_valid(rsp_valid), .out_stall(rsp_stall), .out_res(res)
   );

   assign rsp_next_pc     = res.next_pc;
   assign rsp_halted      = res.halted;
   assign rsp_reg_written = res.reg_written;
   assign rsp_reg_index   = res.reg_index;
   assign rsp_reg_value   = res.reg_value;
   assign rsp_mem_written = res.mem_written;
   assign rsp_mem_addr    = res.mem_addr;
   assign rsp_mem_value   = res.mem_value;
   assign rsp_addr_fault  = res.addr_fault;
endmodule
